@@ src/csrms_pkg.sv @@
// Shared constants, widths and codes for the compressed-sparse-row matrix store.
// No dependencies; the top level imports it.
package csrms_pkg;

  // Capacity of the store
  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 64;
  localparam int MAX_NONZERO = 4096;

  // Derived widths
  localparam int ROW_W      = $clog2(MAX_ROWS + 1);
  localparam int COL_W      = $clog2(MAX_COLS + 1);
  localparam int COL_IDX_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int NZ_W       = $clog2(MAX_NONZERO + 1);
  localparam int NZ_ADDR_W  = (MAX_NONZERO > 1) ? $clog2(MAX_NONZERO) : 1;
  localparam int RS_DEPTH   = MAX_ROWS + 1;
  localparam int CMP_W      = 16;

  // Field widths fixed by the interface
  localparam int ACTION_W   = 2;
  localparam int INDEX_W    = 8;
  localparam int ELEM_W     = 32;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;

  // Entry memory word: column above value
  localparam int ENTRY_W    = COL_IDX_W + VALUE_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'd1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_LOAD   = 2'd1,
    ACT_LOOKUP = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_RANGE   = 2'd1,
    STAT_IGNORED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PTR_LO,
    ST_PTR_HI,
    ST_PTR_END,
    ST_SCAN
  } state_t;

endpackage

@@ src/csrms_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Uses no package; width and depth come from its parameters.
module csrms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/csr_sparse_matrix_store.sv @@
// Compressed-sparse-row matrix store. After a clear request, row_count x col_count
// elements are loaded in row-major order; a load, clear or out-of-range lookup is
// answered straight from the idle state. An in-range lookup steps through ST_PTR_LO,
// ST_PTR_HI and ST_PTR_END to fetch the row's start and end pointers from the
// row-pointer memory, then scans the row's stored entries one at a time in ST_SCAN
// (the entry memory has one read port) until the column is found or the row is
// exhausted. The block is not ready while a lookup is in progress, and takes a new
// request only when the result register is free or being drained. The memories
// need no clearing pass; row pointers not yet written read as zero. Depends on csrms_pkg and csrms_ram.
module csr_sparse_matrix_store
  import csrms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Request stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // action[1:0], row[9:2], col[17:10], element[49:18]
  // Result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,  // value[31:0], status[33:32]
  // Configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  // Request fields
  logic [ACTION_W-1:0]     in_action;
  logic signed [INDEX_W-1:0] in_row;
  logic signed [INDEX_W-1:0] in_col;
  logic [ELEM_W-1:0]       in_element;

  assign in_action  = s_tdata[1:0];
  assign in_row     = s_tdata[9:2];
  assign in_col     = s_tdata[17:10];
  assign in_element = s_tdata[49:18];

  // Configuration and build state
  logic [CFG_W-1:0] row_count;
  logic [CFG_W-1:0] col_count;
  logic [ROW_W-1:0] load_row, load_row_next;
  logic [COL_W-1:0] load_col, load_col_next;
  logic [NZ_W-1:0]  nz_count, nz_count_next;

  // Lookup sequencer
  state_t               state, state_next;
  logic [ROW_W-1:0]     look_row, look_row_next;
  logic [COL_IDX_W-1:0] look_col, look_col_next;
  logic [NZ_W-1:0]      scan_k, scan_k_next;
  logic [NZ_W-1:0]      scan_end, scan_end_next;
  logic                 pend, pend_next;

  // Result register
  logic                out_valid, out_valid_next;
  logic [VALUE_W-1:0]  out_value, out_value_next;
  logic [STATUS_W-1:0] out_status, out_status_next;

  // Memory ports
  logic                 ent_we;
  logic [NZ_ADDR_W-1:0] ent_waddr;
  logic [ENTRY_W-1:0]   ent_wdata;
  logic [ENTRY_W-1:0]   ent_rdata;
  logic                 rs_we;
  logic [ROW_W-1:0]     rs_waddr;
  logic [NZ_W-1:0]      rs_wdata;
  logic [ROW_W-1:0]     rs_raddr;
  logic [NZ_W-1:0]      rs_rdata;
  logic [RS_DEPTH-1:0]  rs_valid;
  logic                 rs_vld_q;
  logic [NZ_W-1:0]      rs_ptr;

  // Effective matrix size
  logic [ROW_W-1:0] rows_eff;
  logic [COL_W-1:0] cols_eff;

  assign rows_eff = (CMP_W'(row_count) > CMP_W'(MAX_ROWS)) ? ROW_W'(MAX_ROWS)
                                                          : ROW_W'(row_count);
  assign cols_eff = (CMP_W'(col_count) > CMP_W'(MAX_COLS)) ? COL_W'(MAX_COLS)
                                                          : COL_W'(col_count);

  // Load-side, lookup and handshake helpers
  logic             load_oob;
  logic             elem_nz;
  logic             nz_full;
  logic [COL_W-1:0] col_inc;
  logic             look_oob;
  logic             accept;
  logic             out_free;

  assign load_oob = (load_row >= rows_eff) || (load_col >= cols_eff);
  assign elem_nz  = |in_element[ELEM_W-2:0];
  assign nz_full  = (nz_count == NZ_W'(MAX_NONZERO));
  assign col_inc  = load_col + COL_W'(1);
  assign look_oob = in_row[INDEX_W-1] || in_col[INDEX_W-1] ||
                    (CMP_W'($unsigned(in_row)) >= CMP_W'(rows_eff)) ||
                    (CMP_W'($unsigned(in_col)) >= CMP_W'(cols_eff));

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  // Row pointers that were never written read as zero
  assign rs_ptr   = rs_vld_q ? rs_rdata : '0;
  assign rs_raddr = (state == ST_PTR_HI) ? (look_row + ROW_W'(1)) : look_row;

  // Entry memory: value and column of each nonzero element
  csrms_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_NONZERO)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (scan_k[NZ_ADDR_W-1:0]),
    .rdata (ent_rdata)
  );

  // Row pointer memory: end pointer of each row, at the row index plus one
  csrms_ram #(
    .WIDTH (NZ_W),
    .DEPTH (RS_DEPTH)
  ) u_row_ram (
    .clk   (clk),
    .we    (rs_we),
    .waddr (rs_waddr),
    .wdata (rs_wdata),
    .raddr (rs_raddr),
    .rdata (rs_rdata)
  );

  // Sequencer: next state, build state, memory writes and result
  always_comb begin
    state_next      = state;
    load_row_next   = load_row;
    load_col_next   = load_col;
    nz_count_next   = nz_count;
    look_row_next   = look_row;
    look_col_next   = look_col;
    scan_k_next     = scan_k;
    scan_end_next   = scan_end;
    pend_next       = pend;
    out_valid_next  = out_valid && !m_tready;
    out_value_next  = out_value;
    out_status_next = out_status;
    ent_we          = 1'b0;
    ent_waddr       = nz_count[NZ_ADDR_W-1:0];
    ent_wdata       = {COL_IDX_W'(load_col), in_element};
    rs_we           = 1'b0;
    rs_waddr        = load_row + ROW_W'(1);
    rs_wdata        = nz_count;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          out_value_next  = '0;
          out_status_next = STAT_OK;
          out_valid_next  = 1'b1;
          case (in_action)
            ACT_CLEAR: begin
              load_row_next = '0;
              load_col_next = '0;
              nz_count_next = '0;
            end
            ACT_LOAD: begin
              if (load_oob) begin
                out_status_next = STAT_IGNORED;
              end else begin
                if (elem_nz) begin
                  if (nz_full) begin
                    out_status_next = STAT_IGNORED;
                  end else begin
                    ent_we        = 1'b1;
                    nz_count_next = nz_count + NZ_W'(1);
                  end
                end
                // Row complete: record its end pointer
                if (col_inc >= cols_eff) begin
                  rs_we         = 1'b1;
                  rs_wdata      = nz_count_next;
                  load_row_next = load_row + ROW_W'(1);
                  load_col_next = '0;
                end else begin
                  load_col_next = col_inc;
                end
              end
            end
            ACT_LOOKUP: begin
              if (look_oob) begin
                out_status_next = STAT_RANGE;
              end else begin
                out_valid_next = 1'b0;
                look_row_next  = ROW_W'($unsigned(in_row));
                look_col_next  = COL_IDX_W'($unsigned(in_col));
                state_next     = ST_PTR_LO;
              end
            end
            default: begin
              out_status_next = STAT_OK;
            end
          endcase
        end
      end
      ST_PTR_LO: begin
        state_next = ST_PTR_HI;
      end
      ST_PTR_HI: begin
        scan_k_next = rs_ptr;
        state_next  = ST_PTR_END;
      end
      ST_PTR_END: begin
        scan_end_next = rs_ptr;
        pend_next     = 1'b0;
        state_next    = ST_SCAN;
      end
      ST_SCAN: begin
        // Compare the entry read last cycle while the next one is fetched
        if (pend && (ent_rdata[ENTRY_W-1:VALUE_W] == look_col)) begin
          out_valid_next  = 1'b1;
          out_value_next  = ent_rdata[VALUE_W-1:0];
          out_status_next = STAT_OK;
          pend_next       = 1'b0;
          state_next      = ST_IDLE;
        end else if (scan_k < scan_end) begin
          scan_k_next = scan_k + NZ_W'(1);
          pend_next   = 1'b1;
        end else begin
          out_valid_next  = 1'b1;
          out_value_next  = '0;
          out_status_next = STAT_OK;
          pend_next       = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      load_row  <= '0;
      load_col  <= '0;
      nz_count  <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
      rs_valid  <= '0;
      rs_vld_q  <= 1'b0;
    end else begin
      load_row  <= load_row_next;
      load_col  <= load_col_next;
      nz_count  <= nz_count_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
      if (rs_we) begin
        rs_valid[rs_waddr] <= 1'b1;
      end
      rs_vld_q <= rs_valid[rs_raddr];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_COUNT: row_count <= cfg_data;
        REG_COL_COUNT: col_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    look_row   <= look_row_next;
    look_col   <= look_col_next;
    scan_k     <= scan_k_next;
    scan_end   <= scan_end_next;
    out_value  <= out_value_next;
    out_status <= out_status_next;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_W - VALUE_W - STATUS_W){1'b0}}, out_status, out_value};

endmodule
